// ----- rtl/core/mp2_pkg.sv -----
// shared types, constants and helpers of the 2x2 max pooling core
package mp2_pkg;

   // sizes of the data path
   localparam int PIXEL_BITS  = 16;
   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int LINE_DEPTH  = MAX_COLS / 2;
   localparam int LINE_AW     = $clog2(LINE_DEPTH);
   localparam int COUNT_BITS  = LINE_AW + 1;
   localparam int SIZE_BITS   = 11;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   // result queue
   localparam int RSP_DEPTH    = 3;
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   // register indexes, taken from paddr[2]
   localparam logic REG_FRAME_ROWS = 1'b0;
   localparam logic REG_FRAME_COLS = 1'b1;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(2);
   localparam logic [SIZE_BITS-1:0] SIZE_MIN   = SIZE_BITS'(2);

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;
   typedef logic [SIZE_BITS-1:0]         size_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic [LINE_AW-1:0]           line_addr_type;
   typedef logic [RSP_CNT_BITS-1:0]      rsp_cnt_type;

   typedef struct packed {
      pixel_type pooled;
      logic      frame_last;
   } rsp_word_type;

   // larger of two signed pixels
   function automatic pixel_type pix_max(input pixel_type a, input pixel_type b);
      pix_max = (a >= b) ? a : b;
   endfunction

   // frame size limited to the supported range
   function automatic size_type clamp_size(input size_type v, input size_type hi);
      if (v < SIZE_MIN) begin
         clamp_size = SIZE_MIN;
      end else if (v > hi) begin
         clamp_size = hi;
      end else begin
         clamp_size = v;
      end
   endfunction

endpackage

// ----- rtl/core/mp2_if.sv -----
// valid/ready channels of the pooling core: pixel words in, pooled words out
interface mp2_req_if;
   logic               valid;
   logic               ready;
   mp2_pkg::pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface mp2_rsp_if;
   logic               valid;
   logic               ready;
   mp2_pkg::pixel_type pooled;
   logic               frame_last;

   modport source (output valid, output pooled, output frame_last, input ready);
   modport sink   (input valid, input pooled, input frame_last, output ready);
endinterface

// ----- rtl/core/mp2_ram.sv -----
// generic single-clock ram, one write and one read port, registered read data
module mp2_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/max_pool_2x2_stream_core.sv -----
// 2x2 stride-2 max pooling over a raster-order stream of signed pixels.
// The core takes one pixel word per clock while the result queue has room
// and returns one word per complete 2x2 window, windows in raster order; a
// trailing odd row or column gives no word. frame_last marks the bottom-right
// window of each frame. A word passes through the registered read of the line
// memory (512 x 16, pair maxima of the even row) and a three-word result
// queue that lets input continue while output stalls. Sizes are written
// through the APB port (frame_rows at 0, frame_cols at 4, range 2..1024,
// values outside are limited); the user must write them only while idle (not
// enforced by the core). The line memory needs no clearing pass after reset.
module max_pool_2x2_stream_core (
   input  logic                          clock,
   input  logic                          reset,
   mp2_req_if.sink                       req,
   mp2_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mp2_pkg::CSR_AW-1:0]    paddr,
   input  logic [mp2_pkg::CSR_DW-1:0]    pwdata,
   output logic [mp2_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);
   import mp2_pkg::*;

   size_type      rows_raw_ff, cols_raw_ff, rows_lim_ff, cols_lim_ff;
   size_type      rows_raw_in, cols_raw_in, rows_lim_in, cols_lim_in;
   size_type      wr_size;
   logic          csr_wr;

   count_type     col_ff, row_ff, col_in, row_in;
   size_type      c0, r0, c, r, c1, r1, rows_even, cols_even;
   logic          active, odd_col, odd_row, accept;

   pixel_type     held_ff, held_in, pm;
   pixel_type     pm_ff;
   logic          last_ff, pend_ff, pend_in, frame_end;
   logic          line_wr, line_rd;
   line_addr_type line_addr;
   pixel_type     line_rd_data;

   rsp_word_type  slot_ff [RSP_DEPTH];
   rsp_word_type  slot_in [RSP_DEPTH];
   rsp_word_type  new_word;
   rsp_cnt_type   cnt_ff, cnt_in, wr_slot;
   logic          pop;

   // register port
   assign csr_wr  = psel && penable && pwrite;
   assign wr_size = pwdata[SIZE_BITS-1:0];
   assign pready  = 1'b1;
   assign prdata  = (paddr[2] == REG_FRAME_COLS) ? CSR_DW'(cols_raw_ff)
                                                 : CSR_DW'(rows_raw_ff);

   always_comb begin
      rows_raw_in = rows_raw_ff;
      cols_raw_in = cols_raw_ff;
      rows_lim_in = rows_lim_ff;
      cols_lim_in = cols_lim_ff;
      if (csr_wr && paddr[2] == REG_FRAME_ROWS) begin
         rows_raw_in = wr_size;
         rows_lim_in = clamp_size(wr_size, SIZE_BITS'(MAX_ROWS));
      end
      if (csr_wr && paddr[2] == REG_FRAME_COLS) begin
         cols_raw_in = wr_size;
         cols_lim_in = clamp_size(wr_size, SIZE_BITS'(MAX_COLS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_raw_ff <= SIZE_RESET;
         cols_raw_ff <= SIZE_RESET;
         rows_lim_ff <= SIZE_RESET;
         cols_lim_ff <= SIZE_RESET;
      end else begin
         rows_raw_ff <= rows_raw_in;
         cols_raw_ff <= cols_raw_in;
         rows_lim_ff <= rows_lim_in;
         cols_lim_ff <= cols_lim_in;
      end
   end

   // position of this pixel and of the next one
   assign rows_even = {rows_lim_ff[SIZE_BITS-1:1], 1'b0};
   assign cols_even = {cols_lim_ff[SIZE_BITS-1:1], 1'b0};
   assign accept    = req.valid && req.ready;

   always_comb begin
      c0 = {1'b0, col_ff};
      r0 = {1'b0, row_ff};
      if (c0 >= cols_lim_ff) begin
         c = '0;
         r = r0 + SIZE_BITS'(1);
      end else begin
         c = c0;
         r = r0;
      end
      if (r >= rows_lim_ff) begin
         r = '0;
      end
      c1 = c + SIZE_BITS'(1);
      r1 = r;
      if (c1 >= cols_lim_ff) begin
         c1 = '0;
         r1 = r + SIZE_BITS'(1);
         if (r1 >= rows_lim_ff) begin
            r1 = '0;
         end
      end
      col_in = accept ? c1[COUNT_BITS-1:0] : col_ff;
      row_in = accept ? r1[COUNT_BITS-1:0] : row_ff;
   end

   assign active    = (c < cols_even) && (r < rows_even);
   assign odd_col   = c[0];
   assign odd_row   = r[0];
   assign frame_end = (r == rows_even - SIZE_BITS'(1)) && (c == cols_even - SIZE_BITS'(1));

   // pair maximum and line memory access
   assign pm        = pix_max(held_ff, req.pixel);
   assign held_in   = (accept && active && !odd_col) ? req.pixel : held_ff;
   assign line_addr = c[COUNT_BITS-1:1];
   assign line_wr   = accept && active && odd_col && !odd_row;
   assign line_rd   = accept && active && odd_col && odd_row;
   assign pend_in   = line_rd;

   mp2_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (line_addr),
      .wr_data (pm),
      .rd_en   (line_rd),
      .rd_addr (line_addr),
      .rd_data (line_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
         pend_ff <= pend_in;
      end
   end

   // window data that waits for the line read
   always_ff @(posedge clock) begin
      if (line_rd) begin
         pm_ff   <= pm;
         last_ff <= frame_end;
      end
   end

   // result queue, head word drives the output
   assign new_word.pooled     = pix_max(line_rd_data, pm_ff);
   assign new_word.frame_last = last_ff;
   assign pop                 = rsp.valid && rsp.ready;
   assign wr_slot             = cnt_ff - rsp_cnt_type'(pop);
   assign cnt_in              = cnt_ff + rsp_cnt_type'(pend_ff) - rsp_cnt_type'(pop);

   always_comb begin
      for (int i = 0; i < RSP_DEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i+1] : slot_ff[i];
      end
      slot_in[RSP_DEPTH-1] = slot_ff[RSP_DEPTH-1];
      for (int i = 0; i < RSP_DEPTH; i++) begin
         if (pend_ff && wr_slot == rsp_cnt_type'(i)) begin
            slot_in[i] = new_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // output side and input flow control
   assign rsp.valid      = (cnt_ff != '0);
   assign rsp.pooled     = slot_ff[0].pooled;
   assign rsp.frame_last = slot_ff[0].frame_last;
   assign req.ready      = ({1'b0, cnt_ff} + (RSP_CNT_BITS+1)'(pend_ff))
                           < (RSP_CNT_BITS+1)'(RSP_DEPTH);

   // a pending line read always finds room in the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && cnt_ff == RSP_CNT_BITS'(RSP_DEPTH) && !pop))
      else $error("result queue overflow");

   // a pending window word (pend_ff) makes the output valid on the next cycle
   a_pend_lands: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp.valid)
      else $error("window word lost");

   // one row either fills or reads the line memory, never both at once
   a_line_port: assert property (@(posedge clock) disable iff (reset)
      !(line_wr && line_rd))
      else $error("line memory write and read together");

endmodule
